// ===== src/pid_speed_controller_unit_assert.svh =====
// Assertion helpers used by the controller sequencer.
`ifndef PID_SPEED_CONTROLLER_UNIT_ASSERT_SVH
`define PID_SPEED_CONTROLLER_UNIT_ASSERT_SVH

// Consequent must hold in the clock after the antecedent.
`define PSC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same clock as the antecedent.
`define PSC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== src/psc_pkg.sv =====
package psc_pkg;

    // Field and register widths
    localparam int SPEED_W   = 11;
    localparam int TIME_W    = 32;
    localparam int GAIN_W    = 16;
    localparam int ILIM_W    = 23;
    localparam int DLIM_W    = 15;
    localparam int DRIVE_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 23;

    // Internal datapath widths
    localparam int ERR_W   = 12;   // target - measured
    localparam int DERR_W  = 13;   // error difference
    localparam int DT_W    = 7;    // elapsed ms, 1..100
    localparam int INTEG_W = 24;   // error integral
    localparam int SUM_W   = INTEG_W + 1;
    localparam int DK_W    = 17;   // 1000 * d
    localparam int ED_W    = 19;   // e * d
    localparam int P1_W    = 28;   // Kp * e
    localparam int KID_W   = 23;   // Ki * d
    localparam int DD_W    = 29;   // Kd * de
    localparam int ACC_W   = 50;   // numerator
    localparam int MAG_W   = 49;   // numerator magnitude / quotient
    localparam int DEN_W   = 21;   // 16000 * d
    localparam int MUL_A_W = 30;
    localparam int MUL_B_W = 25;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Divider sweeps one quotient bit per cycle
    localparam int DIV_STEPS = MAG_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Arithmetic constants
    localparam logic [DT_W-1:0] TIME_DEFAULT_MS = 7'd10;
    localparam logic [DT_W-1:0] TIME_MAX_MS     = 7'd100;
    localparam int MS_PER_S    = 1000;
    localparam int DERIV_SCALE = 1000000;
    localparam int DEN_SCALE   = 16000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_LIMIT = 3'd4;

    // Register reset values
    localparam logic [GAIN_W-1:0] PROP_GAIN_RST   = 16'd3277;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST  = 16'd205;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST  = 16'd41;
    localparam logic [ILIM_W-1:0] INTEG_LIMIT_RST = 23'd200000;
    localparam logic [DLIM_W-1:0] DRIVE_LIMIT_RST = 15'd25600;

    // Datapath operations, one per cycle
    typedef enum logic [4:0] {
        OP_IDLE,
        OP_DIFF,
        OP_DSEL,
        OP_MUL_DK,
        OP_MUL_ED,
        OP_INTEG,
        OP_MUL_P1,
        OP_MUL_PT,
        OP_MUL_KID,
        OP_MUL_IT,
        OP_ADD,
        OP_MUL_DD,
        OP_MUL_DTM,
        OP_MUL_DEN,
        OP_ABS,
        OP_RND,
        OP_DIV,
        OP_SAT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic load_in;
        logic load_out;
    } psc_cmd_t;

endpackage

// ===== src/psc_ctrl.sv =====
`include "pid_speed_controller_unit_assert.svh"

module psc_ctrl
    import psc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output psc_cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DIFF,
        ST_DSEL,
        ST_MUL_DK,
        ST_MUL_ED,
        ST_INTEG,
        ST_MUL_P1,
        ST_MUL_PT,
        ST_MUL_KID,
        ST_MUL_IT,
        ST_ADD_I,
        ST_MUL_DD,
        ST_MUL_DTM,
        ST_ADD_D,
        ST_MUL_DEN,
        ST_ABS,
        ST_RND,
        ST_DIV,
        ST_SAT
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] div_cnt_reg;
    logic             m_valid_reg;
    logic             load_out;
    op_t              op;

    assign s_ready  = (state_reg == ST_IDLE);
    assign load_out = (state_reg == ST_SAT) && (!m_valid_reg || m_ready);
    assign m_valid  = m_valid_reg;

    // Operation issued in each state
    always_comb begin
        case (state_reg)
            ST_DIFF:    op = OP_DIFF;
            ST_DSEL:    op = OP_DSEL;
            ST_MUL_DK:  op = OP_MUL_DK;
            ST_MUL_ED:  op = OP_MUL_ED;
            ST_INTEG:   op = OP_INTEG;
            ST_MUL_P1:  op = OP_MUL_P1;
            ST_MUL_PT:  op = OP_MUL_PT;
            ST_MUL_KID: op = OP_MUL_KID;
            ST_MUL_IT:  op = OP_MUL_IT;
            ST_ADD_I:   op = OP_ADD;
            ST_MUL_DD:  op = OP_MUL_DD;
            ST_MUL_DTM: op = OP_MUL_DTM;
            ST_ADD_D:   op = OP_ADD;
            ST_MUL_DEN: op = OP_MUL_DEN;
            ST_ABS:     op = OP_ABS;
            ST_RND:     op = OP_RND;
            ST_DIV:     op = OP_DIV;
            ST_SAT:     op = OP_SAT;
            default:    op = OP_IDLE;
        endcase
    end

    assign cmd.op       = op;
    assign cmd.load_in  = s_valid && s_ready;
    assign cmd.load_out = load_out;

    // Sequencer and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            div_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) state_reg <= ST_DIFF;
                end
                ST_DIFF:    state_reg <= ST_DSEL;
                ST_DSEL:    state_reg <= ST_MUL_DK;
                ST_MUL_DK:  state_reg <= ST_MUL_ED;
                ST_MUL_ED:  state_reg <= ST_INTEG;
                ST_INTEG:   state_reg <= ST_MUL_P1;
                ST_MUL_P1:  state_reg <= ST_MUL_PT;
                ST_MUL_PT:  state_reg <= ST_MUL_KID;
                ST_MUL_KID: state_reg <= ST_MUL_IT;
                ST_MUL_IT:  state_reg <= ST_ADD_I;
                ST_ADD_I:   state_reg <= ST_MUL_DD;
                ST_MUL_DD:  state_reg <= ST_MUL_DTM;
                ST_MUL_DTM: state_reg <= ST_ADD_D;
                ST_ADD_D:   state_reg <= ST_MUL_DEN;
                ST_MUL_DEN: state_reg <= ST_ABS;
                ST_ABS:     state_reg <= ST_RND;
                ST_RND: begin
                    state_reg   <= ST_DIV;
                    div_cnt_reg <= '0;
                end
                ST_DIV: begin
                    if (div_cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                        state_reg <= ST_SAT;
                    end else begin
                        div_cnt_reg <= div_cnt_reg + 1'b1;
                    end
                end
                ST_SAT: begin
                    if (!m_valid_reg || m_ready) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `PSC_ASSERT_NEXT(a_accept_starts, aclk, aresetn, s_valid && s_ready,
        state_reg == ST_DIFF, "accepted word did not start the sequence")
    `PSC_ASSERT_NOW(a_valid_from_sat, aclk, aresetn, $rose(m_valid_reg),
        $past(state_reg) == ST_SAT, "result raised outside the saturate step")
    `PSC_ASSERT_NEXT(a_sat_holds, aclk, aresetn,
        state_reg == ST_SAT && m_valid_reg && !m_ready,
        state_reg == ST_SAT, "result overwritten while output stalled")
    `PSC_ASSERT_NOW(a_div_count, aclk, aresetn, state_reg == ST_DIV,
        div_cnt_reg < CNT_W'(DIV_STEPS), "divider count out of range")

endmodule

// ===== src/psc_datapath.sv =====
module psc_datapath
    import psc_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  psc_cmd_t                   cmd,
    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_wdata,
    input  logic signed [SPEED_W-1:0]  s_target_speed,
    input  logic signed [SPEED_W-1:0]  s_measured_speed,
    input  logic [TIME_W-1:0]          s_now_ms,
    output logic signed [DRIVE_W-1:0]  m_drive
);

    // Configuration and persistent state
    logic [GAIN_W-1:0]         kp_reg, ki_reg, kd_reg;
    logic [ILIM_W-1:0]         ilim_reg;
    logic [DLIM_W-1:0]         dlim_reg;
    logic [TIME_W-1:0]         prev_time_reg;
    logic signed [ERR_W-1:0]   prev_err_reg;
    logic signed [INTEG_W-1:0] integ_reg;

    // Working registers
    logic signed [SPEED_W-1:0] tgt_reg, meas_reg;
    logic [TIME_W-1:0]         now_reg;
    logic [TIME_W-1:0]         dt_reg;
    logic signed [ERR_W-1:0]   e_reg;
    logic signed [DERR_W-1:0]  de_reg;
    logic [DT_W-1:0]           d_reg;
    logic [DK_W-1:0]           dk_reg;
    logic signed [ED_W-1:0]    ed_reg;
    logic signed [P1_W-1:0]    p1_reg;
    logic [KID_W-1:0]          kid_reg;
    logic signed [DD_W-1:0]    dd_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   term_reg;
    logic [DEN_W-1:0]          den_reg;
    logic [MAG_W-1:0]          mag_reg;
    logic                      neg_reg;
    logic [DEN_W-1:0]          rem_reg;
    logic signed [DRIVE_W-1:0] drive_reg;

    // Combinational values
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic signed [ERR_W-1:0]   e_next;
    logic signed [DERR_W-1:0]  de_next;
    logic [DT_W-1:0]           d_next;
    logic signed [SUM_W-1:0]   integ_sum, ilim_pos, ilim_neg;
    logic signed [INTEG_W-1:0] integ_next;
    logic signed [ACC_W-1:0]   acc_neg;
    logic [MAG_W-1:0]          mag_abs;
    logic [DEN_W:0]            rem_sh, rem_diff;
    logic                      q_bit;
    logic [DEN_W-1:0]          rem_next;
    logic [DLIM_W-1:0]         q_sat;
    logic [DRIVE_W-1:0]        drive_mag;
    logic [DRIVE_W-1:0]        drive_next;

    // Shared multiplier, operands picked by the current step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MUL_DK: begin
                mul_a = signed'(MUL_A_W'(d_reg));
                mul_b = MUL_B_W'(MS_PER_S);
            end
            OP_MUL_ED: begin
                mul_a = MUL_A_W'(e_reg);
                mul_b = signed'(MUL_B_W'(d_reg));
            end
            OP_MUL_P1: begin
                mul_a = signed'(MUL_A_W'(kp_reg));
                mul_b = MUL_B_W'(e_reg);
            end
            OP_MUL_PT: begin
                mul_a = MUL_A_W'(p1_reg);
                mul_b = signed'(MUL_B_W'(dk_reg));
            end
            OP_MUL_KID: begin
                mul_a = signed'(MUL_A_W'(ki_reg));
                mul_b = signed'(MUL_B_W'(d_reg));
            end
            OP_MUL_IT: begin
                mul_a = signed'(MUL_A_W'(kid_reg));
                mul_b = MUL_B_W'(integ_reg);
            end
            OP_MUL_DD: begin
                mul_a = signed'(MUL_A_W'(kd_reg));
                mul_b = MUL_B_W'(de_reg);
            end
            OP_MUL_DTM: begin
                mul_a = MUL_A_W'(dd_reg);
                mul_b = MUL_B_W'(DERIV_SCALE);
            end
            OP_MUL_DEN: begin
                mul_a = signed'(MUL_A_W'(d_reg));
                mul_b = MUL_B_W'(DEN_SCALE);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Error, error difference and elapsed-time clamp
    assign e_next  = ERR_W'(tgt_reg) - ERR_W'(meas_reg);
    assign de_next = (prev_err_reg != '0) ? (DERR_W'(e_reg) - DERR_W'(prev_err_reg)) : '0;

    always_comb begin
        if (dt_reg == '0) begin
            d_next = TIME_DEFAULT_MS;
        end else if (dt_reg > TIME_W'(TIME_MAX_MS)) begin
            d_next = TIME_MAX_MS;
        end else begin
            d_next = dt_reg[DT_W-1:0];
        end
    end

    // Integral update with symmetric clamp
    assign integ_sum = SUM_W'(integ_reg) + SUM_W'(ed_reg);
    assign ilim_pos  = signed'(SUM_W'(ilim_reg));
    assign ilim_neg  = -ilim_pos;

    always_comb begin
        if (integ_sum > ilim_pos) begin
            integ_next = INTEG_W'(ilim_pos);
        end else if (integ_sum < ilim_neg) begin
            integ_next = INTEG_W'(ilim_neg);
        end else begin
            integ_next = INTEG_W'(integ_sum);
        end
    end

    // Magnitude of the numerator
    assign acc_neg = -acc_reg;
    assign mag_abs = acc_reg[ACC_W-1] ? acc_neg[MAG_W-1:0] : acc_reg[MAG_W-1:0];

    // One restoring divide step, quotient bits shift into mag_reg
    assign rem_sh   = {rem_reg, mag_reg[MAG_W-1]};
    assign rem_diff = rem_sh - {1'b0, den_reg};
    assign q_bit    = ~rem_diff[DEN_W];
    assign rem_next = q_bit ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];

    // Clamp the quotient and restore the sign
    assign q_sat      = (mag_reg > MAG_W'(dlim_reg)) ? dlim_reg : mag_reg[DLIM_W-1:0];
    assign drive_mag  = DRIVE_W'(q_sat);
    assign drive_next = neg_reg ? (~drive_mag + 1'b1) : drive_mag;

    // Configuration and state carried between words
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg        <= PROP_GAIN_RST;
            ki_reg        <= INTEG_GAIN_RST;
            kd_reg        <= DERIV_GAIN_RST;
            ilim_reg      <= INTEG_LIMIT_RST;
            dlim_reg      <= DRIVE_LIMIT_RST;
            prev_time_reg <= '0;
            prev_err_reg  <= '0;
            integ_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_PROP_GAIN:   kp_reg   <= cfg_wdata[GAIN_W-1:0];
                    CFG_INTEG_GAIN:  ki_reg   <= cfg_wdata[GAIN_W-1:0];
                    CFG_DERIV_GAIN:  kd_reg   <= cfg_wdata[GAIN_W-1:0];
                    CFG_INTEG_LIMIT: ilim_reg <= cfg_wdata[ILIM_W-1:0];
                    CFG_DRIVE_LIMIT: dlim_reg <= cfg_wdata[DLIM_W-1:0];
                    default: ;
                endcase
            end
            case (cmd.op)
                OP_DIFF:  prev_time_reg <= now_reg;
                OP_DSEL:  prev_err_reg  <= e_reg;
                OP_INTEG: integ_reg     <= integ_next;
                default: ;
            endcase
        end
    end

    // Working registers of the current word
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            tgt_reg  <= s_target_speed;
            meas_reg <= s_measured_speed;
            now_reg  <= s_now_ms;
        end
        if (cmd.load_out) begin
            drive_reg <= signed'(drive_next);
        end
        case (cmd.op)
            OP_DIFF: begin
                e_reg  <= e_next;
                dt_reg <= now_reg - prev_time_reg;
            end
            OP_DSEL: begin
                d_reg  <= d_next;
                de_reg <= de_next;
            end
            OP_MUL_DK:  dk_reg   <= mul_p[DK_W-1:0];
            OP_MUL_ED:  ed_reg   <= mul_p[ED_W-1:0];
            OP_MUL_P1:  p1_reg   <= mul_p[P1_W-1:0];
            OP_MUL_PT:  acc_reg  <= mul_p[ACC_W-1:0];
            OP_MUL_KID: kid_reg  <= mul_p[KID_W-1:0];
            OP_MUL_IT:  term_reg <= mul_p[ACC_W-1:0];
            OP_ADD:     acc_reg  <= acc_reg + term_reg;
            OP_MUL_DD:  dd_reg   <= mul_p[DD_W-1:0];
            OP_MUL_DTM: term_reg <= mul_p[ACC_W-1:0];
            OP_MUL_DEN: den_reg  <= mul_p[DEN_W-1:0];
            OP_ABS: begin
                neg_reg <= acc_reg[ACC_W-1];
                mag_reg <= mag_abs;
            end
            OP_RND: begin
                mag_reg <= mag_reg + MAG_W'(den_reg[DEN_W-1:1]);
                rem_reg <= '0;
            end
            OP_DIV: begin
                rem_reg <= rem_next;
                mag_reg <= {mag_reg[MAG_W-2:0], q_bit};
            end
            default: ;
        endcase
    end

    assign m_drive = drive_reg;

endmodule

// ===== src/pid_speed_controller_unit.sv =====
// Positional PID speed controller with integral anti-windup.
// Input channel (s_valid/s_ready): one word holds a target speed, a measured
// speed and a millisecond timestamp. Output channel (m_valid/m_ready): one
// word holds the clamped drive value, one result per input word.
// Configuration: cfg_wr_en writes cfg_wdata into register cfg_index
// (0 prop gain, 1 integral gain, 2 derivative gain, 3 integral limit,
// 4 drive limit) in the same cycle; write only while the block is idle.
// A 16-step sequence of subtracts, clamps, shared-multiplier products and
// accumulates forms the rounded numerator magnitude and divisor, then a
// restoring divider yields one quotient bit a cycle and a final step clamps
// the result. No new word is taken until the sequencer finishes the last one;
// s_ready is high only while the sequencer is idle.
// The result sits in an output register: the next word is accepted while it
// waits. If the receiver still stalls when the following result is ready,
// the sequencer holds in its final step until the register frees up.
// Reset (aresetn low, synchronous): gains and limits return to their defaults,
// previous time, previous error and integral clear, and no result is pending.
module pid_speed_controller_unit
    import psc_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [SPEED_W-1:0] s_target_speed,
    input  logic signed [SPEED_W-1:0] s_measured_speed,
    input  logic [TIME_W-1:0]         s_now_ms,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [DRIVE_W-1:0] m_drive,
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_wdata
);

    psc_cmd_t cmd;

    psc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    psc_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_target_speed   (s_target_speed),
        .s_measured_speed (s_measured_speed),
        .s_now_ms         (s_now_ms),
        .m_drive          (m_drive)
    );

endmodule
